FILE: hdl/tkdlp_pkg.sv
// ----------------------------------------------------------------------------
// tkdlp_pkg
// shared types and constants for the two-key debounce / long-press block
// ----------------------------------------------------------------------------
package tkdlp_pkg;

  localparam int unsigned DebounceW = 8;
  localparam int unsigned LongW     = 16;
  localparam int unsigned CountW    = 16;
  localparam int unsigned EventW    = 3;
  localparam int unsigned CfgDataW  = 16;
  localparam int unsigned CfgIndexW = 1;

  localparam logic [DebounceW-1:0] DebounceReset = DebounceW'(10);
  localparam logic [LongW-1:0]     LongReset     = LongW'(5 * 90 * 3);

  // register indexes
  localparam logic [CfgIndexW-1:0] RegDebounce = 1'b0;
  localparam logic [CfgIndexW-1:0] RegLong     = 1'b1;

  // pressed code, bit 0 key one, bit 1 key two
  localparam logic [1:0] KeysNone = 2'b00;
  localparam logic [1:0] KeysBoth = 2'b11;

  // event codes
  localparam logic [EventW-1:0] EvNone = 3'd0;
  localparam logic [EventW-1:0] EvBoth = 3'd5;
  localparam logic [EventW-1:0] LongStep = 3'd2;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'b00001,
    PH_DEBOUNCE = 5'b00010,
    PH_HELD     = 5'b00100,
    PH_LONG     = 5'b01000,
    PH_RELEASE  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [DebounceW-1:0] debounce_ticks;
    logic [LongW-1:0]     long_press_ticks;
  } cfg_t;

endpackage

FILE: hdl/tkdlp_if.sv
// ----------------------------------------------------------------------------
// tkdlp_key_if / tkdlp_event_if
// valid/ready channels for key samples and for event codes
// ----------------------------------------------------------------------------
interface tkdlp_key_if;
  logic valid;
  logic ready;
  logic key_one_level;
  logic key_two_level;

  modport source (output valid, output key_one_level, output key_two_level, input ready);
  modport sink   (input valid, input key_one_level, input key_two_level, output ready);
endinterface

interface tkdlp_event_if;
  logic                           valid;
  logic                           ready;
  logic [tkdlp_pkg::EventW-1:0]   event_code;

  modport source (output valid, output event_code, input ready);
  modport sink   (input valid, input event_code, output ready);
endinterface

FILE: hdl/tkdlp_fsm.sv
// ----------------------------------------------------------------------------
// tkdlp_fsm
// scan state machine: phase, latched press code and tick counter
// ----------------------------------------------------------------------------
module tkdlp_fsm (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          step,
  input  logic [1:0]                    keys_pressed,
  input  tkdlp_pkg::cfg_t               cfg,
  output logic [tkdlp_pkg::EventW-1:0]  ev
);

  tkdlp_pkg::phase_t                   phase, phase_next;
  logic [tkdlp_pkg::EventW-1:0]        press_code, press_code_next;
  logic [tkdlp_pkg::CountW-1:0]        tick_counter, tick_counter_next;
  logic [tkdlp_pkg::CountW-1:0]        cnt_dec;
  logic                                cnt_zero;

  // counter drops before the scan logic looks at it
  assign cnt_dec  = (tick_counter != '0) ? tick_counter - 1'b1 : tick_counter;
  assign cnt_zero = (cnt_dec == '0);

  always_comb begin
    phase_next        = phase;
    press_code_next   = press_code;
    tick_counter_next = cnt_dec;
    ev                = tkdlp_pkg::EvNone;
    unique case (phase)
      tkdlp_pkg::PH_IDLE: begin
        press_code_next = '0;
        if (keys_pressed != tkdlp_pkg::KeysNone) begin
          phase_next        = tkdlp_pkg::PH_DEBOUNCE;
          tick_counter_next = tkdlp_pkg::CountW'(cfg.debounce_ticks);
        end
      end
      tkdlp_pkg::PH_DEBOUNCE: begin
        if (cnt_zero) begin
          press_code_next = tkdlp_pkg::EventW'(keys_pressed);
          if (keys_pressed != tkdlp_pkg::KeysNone) begin
            phase_next        = tkdlp_pkg::PH_HELD;
            tick_counter_next = cfg.long_press_ticks;
          end else begin
            phase_next = tkdlp_pkg::PH_IDLE;
          end
        end
      end
      tkdlp_pkg::PH_HELD: begin
        if (keys_pressed == tkdlp_pkg::KeysBoth) begin
          ev = tkdlp_pkg::EvBoth;
        end else if (keys_pressed == tkdlp_pkg::KeysNone) begin
          phase_next        = tkdlp_pkg::PH_RELEASE;
          tick_counter_next = tkdlp_pkg::CountW'(cfg.debounce_ticks);
        end else if (cnt_zero) begin
          press_code_next = press_code + tkdlp_pkg::LongStep;
          ev              = press_code + tkdlp_pkg::LongStep;
          phase_next      = tkdlp_pkg::PH_LONG;
        end
      end
      tkdlp_pkg::PH_LONG: begin
        if (keys_pressed == tkdlp_pkg::KeysNone) begin
          press_code_next   = '0;
          phase_next        = tkdlp_pkg::PH_RELEASE;
          tick_counter_next = tkdlp_pkg::CountW'(cfg.debounce_ticks);
        end
      end
      tkdlp_pkg::PH_RELEASE: begin
        if (cnt_zero) begin
          ev         = press_code;
          phase_next = tkdlp_pkg::PH_IDLE;
        end
      end
      default: begin
        phase_next = tkdlp_pkg::PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= tkdlp_pkg::PH_IDLE;
      press_code   <= '0;
      tick_counter <= '0;
    end else if (step) begin
      phase        <= phase_next;
      press_code   <= press_code_next;
      tick_counter <= tick_counter_next;
    end
  end

endmodule

FILE: hdl/two_key_debounce_long_press.sv
// ----------------------------------------------------------------------------
// two_key_debounce_long_press
// two-key debounce with short press, long press and both-held events
// ----------------------------------------------------------------------------
// Each beat on keys is one scan tick with the two active-low key levels;
// every tick yields exactly one beat on events, in the next cycle, carrying
// 0 (nothing), 1/2 (short press of key one/two), 3 (key one long or both
// short), 4 (key two long) or 5 (both keys held, repeated every tick).
// One tick is taken per clock; the result sits in one output register, so
// the only stall comes from a full output register whose beat is not taken.
// Debounce and long-press times count in ticks, not clocks; the user sets
// them through the write port (index 0 debounce, index 1 long press) only
// while no tick is in flight, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module two_key_debounce_long_press (
  input  logic                            clk,
  input  logic                            rst,
  tkdlp_key_if.sink                       keys,
  tkdlp_event_if.source                   events,
  input  logic                            cfg_we,
  input  logic [tkdlp_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [tkdlp_pkg::CfgDataW-1:0]  cfg_data
);

  tkdlp_pkg::cfg_t                 cfg;
  logic                            step;
  logic [1:0]                      keys_pressed;
  logic [tkdlp_pkg::EventW-1:0]    ev;
  logic                            out_valid;
  logic [tkdlp_pkg::EventW-1:0]    out_code;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks   <= tkdlp_pkg::DebounceReset;
      cfg.long_press_ticks <= tkdlp_pkg::LongReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        tkdlp_pkg::RegDebounce: cfg.debounce_ticks   <= cfg_data[tkdlp_pkg::DebounceW-1:0];
        tkdlp_pkg::RegLong:     cfg.long_press_ticks <= cfg_data[tkdlp_pkg::LongW-1:0];
        default: ;
      endcase
    end
  end

  // take a tick whenever the output register is empty or being drained
  assign keys.ready   = ~out_valid | events.ready;
  assign step         = keys.valid & keys.ready;

  // pins are active low
  assign keys_pressed = {~keys.key_two_level, ~keys.key_one_level};

  tkdlp_fsm u_fsm (
    .clk          (clk),
    .rst          (rst),
    .step         (step),
    .keys_pressed (keys_pressed),
    .cfg          (cfg),
    .ev           (ev)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (keys.ready) begin
      out_valid <= keys.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_code <= ev;
    end
  end

  assign events.valid      = out_valid;
  assign events.event_code = out_code;

endmodule

FILE: hdl/tkdlp_checker.sv
// ----------------------------------------------------------------------------
// tkdlp_checker
// port-level checks for the two-key debounce block
// ----------------------------------------------------------------------------
module tkdlp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [tkdlp_pkg::EventW-1:0]  event_code
);

  // every accepted tick shows up as a beat on the next cycle
  a_tick_to_beat: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("accepted tick gave no event beat");

  // no beat without a tick behind it
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !out_valid && !(in_valid && in_ready) |=> !out_valid)
    else $error("event beat without a tick");

  // event codes stay in range
  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> event_code <= tkdlp_pkg::EvBoth)
    else $error("event code out of range");

  // an empty output register never blocks the input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(event_code))
    else $error("stalled event beat changed");

endmodule

bind two_key_debounce_long_press tkdlp_checker u_tkdlp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (keys.valid),
  .in_ready   (keys.ready),
  .out_valid  (events.valid),
  .out_ready  (events.ready),
  .event_code (events.event_code)
);

FILE: tb/two_key_debounce_long_press_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// two_key_debounce_long_press_tb
// self-checking bench for the two-key debounce / long-press block
// ----------------------------------------------------------------------------
// A scoreboard class keeps its own copy of the scan state (phase, press code,
// tick counter) and of the two timing registers. Every key beat taken by the
// block is run through it and the resulting event code is queued. Every event
// beat is checked against the oldest queued code. Stimulus starts with a
// short hand-written run of presses, then goes through several timing
// settings with randomized press / hold / release sequences, key bounce and
// noise, under different amounts of sender idling and receiver stalling.
// ----------------------------------------------------------------------------
module two_key_debounce_long_press_tb;

  localparam int unsigned HalfPeriod = 4;
  localparam int unsigned ResetCycles = 11;
  localparam int unsigned HoldCycles = 300;   // long receiver hold-off
  localparam int unsigned QuietLimit = 4000;  // cycles with no beat at all

  // single-key patterns, bit 0 key one, bit 1 key two (1 = pressed)
  localparam logic [1:0] KeysOne = 2'b01;
  localparam logic [1:0] KeysTwo = 2'b10;

  // hand-written run: key one short, key two long, both held then key one
  // alone until the long time runs out (long event from a both-keys code)
  localparam logic [1:0] DirectedPresses [0:27] = '{
    KeysOne, KeysOne, KeysOne,
    tkdlp_pkg::KeysNone, tkdlp_pkg::KeysNone, tkdlp_pkg::KeysNone,
    KeysTwo, KeysTwo, KeysTwo, KeysTwo, KeysTwo, KeysTwo, KeysTwo,
    tkdlp_pkg::KeysNone, tkdlp_pkg::KeysNone, tkdlp_pkg::KeysNone,
    tkdlp_pkg::KeysBoth, tkdlp_pkg::KeysBoth, tkdlp_pkg::KeysBoth,
    KeysOne, KeysOne, KeysOne, KeysOne, KeysOne,
    tkdlp_pkg::KeysNone, tkdlp_pkg::KeysNone, tkdlp_pkg::KeysNone,
    tkdlp_pkg::KeysNone
  };

  // scan-state predictor and store of expected event codes
  class tick_scoreboard;
    logic [tkdlp_pkg::DebounceW-1:0] debounce_ticks;
    logic [tkdlp_pkg::LongW-1:0]     long_press_ticks;
    tkdlp_pkg::phase_t               phase;
    logic [tkdlp_pkg::EventW-1:0]    press_code;
    logic [tkdlp_pkg::CountW-1:0]    tick_count;
    logic [tkdlp_pkg::EventW-1:0]    expected_events[$];
    int                              errors;

    function new();
      debounce_ticks   = tkdlp_pkg::DebounceReset;
      long_press_ticks = tkdlp_pkg::LongReset;
      phase            = tkdlp_pkg::PH_IDLE;
      press_code       = '0;
      tick_count       = '0;
      errors           = 0;
    endfunction

    function void write_reg(logic [tkdlp_pkg::CfgIndexW-1:0] index,
                            logic [tkdlp_pkg::CfgDataW-1:0] data);
      case (index)
        tkdlp_pkg::RegDebounce: debounce_ticks = data[tkdlp_pkg::DebounceW-1:0];
        tkdlp_pkg::RegLong:     long_press_ticks = data[tkdlp_pkg::LongW-1:0];
        default: ;
      endcase
    endfunction

    function void note_tick(logic key_one, logic key_two);
      logic [1:0]                   pressed;
      logic [tkdlp_pkg::EventW-1:0] ev;
      pressed = ~{key_two, key_one};
      ev = tkdlp_pkg::EvNone;
      if (tick_count != '0) tick_count = tick_count - 1'b1;
      case (phase)
        tkdlp_pkg::PH_IDLE: begin
          if (pressed != tkdlp_pkg::KeysNone) begin
            phase = tkdlp_pkg::PH_DEBOUNCE;
            tick_count = tkdlp_pkg::CountW'(debounce_ticks);
          end
          press_code = '0;
        end
        tkdlp_pkg::PH_DEBOUNCE: begin
          if (tick_count == '0) begin
            press_code = tkdlp_pkg::EventW'(pressed);
            if (pressed != tkdlp_pkg::KeysNone) begin
              phase = tkdlp_pkg::PH_HELD;
              tick_count = tkdlp_pkg::CountW'(long_press_ticks);
            end else begin
              phase = tkdlp_pkg::PH_IDLE;
            end
          end
        end
        tkdlp_pkg::PH_HELD: begin
          if (pressed == tkdlp_pkg::KeysBoth) begin
            ev = tkdlp_pkg::EvBoth;
          end else if (pressed == tkdlp_pkg::KeysNone) begin
            phase = tkdlp_pkg::PH_RELEASE;
            tick_count = tkdlp_pkg::CountW'(debounce_ticks);
          end else if (tick_count == '0) begin
            press_code = press_code + tkdlp_pkg::LongStep;
            ev = press_code;
            phase = tkdlp_pkg::PH_LONG;
          end
        end
        tkdlp_pkg::PH_LONG: begin
          if (pressed == tkdlp_pkg::KeysNone) begin
            press_code = '0;
            phase = tkdlp_pkg::PH_RELEASE;
            tick_count = tkdlp_pkg::CountW'(debounce_ticks);
          end
        end
        tkdlp_pkg::PH_RELEASE: begin
          if (tick_count == '0) begin
            ev = press_code;
            phase = tkdlp_pkg::PH_IDLE;
          end
        end
        default: phase = tkdlp_pkg::PH_IDLE;
      endcase
      expected_events.push_back(ev);
    endfunction

    function void check_event(logic [tkdlp_pkg::EventW-1:0] got);
      logic [tkdlp_pkg::EventW-1:0] want;
      if (expected_events.size() == 0) begin
        $error("event_code: expected none, actual %0d", got);
        errors++;
      end else begin
        want = expected_events.pop_front();
        if (got !== want) begin
          $error("event_code: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_events.size();
    endfunction
  endclass

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [tkdlp_pkg::CfgIndexW-1:0] cfg_index;
  logic [tkdlp_pkg::CfgDataW-1:0]  cfg_data;

  tkdlp_key_if   key_bus ();
  tkdlp_event_if event_bus ();

  tick_scoreboard tracker;

  int send_idle_pct;        // used by the sender only
  int stall_pct;            // read by the receiver process
  int ticks_sent;
  int hold_requests;        // bumped by the main flow to ask for a hold-off
  int hold_served;
  int hold_left;
  int quiet_cycles;

  two_key_debounce_long_press uut (
    .clk       (clk),
    .rst       (rst),
    .keys      (key_bus),
    .events    (event_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(HalfPeriod) clk = ~clk;

  // event side: random stalls, plus a long hold-off whenever one is asked for
  always @(posedge clk) begin
    if (hold_left != 0) begin
      event_bus.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HoldCycles;
      event_bus.ready <= 1'b0;
    end else begin
      event_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // every event beat is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && event_bus.valid && event_bus.ready) tracker.check_event(event_bus.event_code);
  end

  // watchdog on stretches where neither side moves a beat
  always @(posedge clk) begin
    if (rst || (key_bus.valid && key_bus.ready) || (event_bus.valid && event_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("two_key_debounce_long_press_tb: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one scan tick, levels active low; optional idle gap before it
  task automatic send_tick(logic key_one, logic key_two);
    if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      key_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    key_bus.valid <= 1'b1;
    key_bus.key_one_level <= key_one;
    key_bus.key_two_level <= key_two;
    do @(posedge clk); while (!key_bus.ready);
    tracker.note_tick(key_one, key_two);
    ticks_sent++;
  endtask

  task automatic send_pressed(logic [1:0] pressed, int count);
    repeat (count) send_tick(~pressed[0], ~pressed[1]);
  endtask

  // contact bounce: random levels
  task automatic send_noise(int count);
    repeat (count) send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // bounce, hold, bounce, release long enough for the release debounce
  task automatic play_press(int dbn, int lng);
    logic [1:0] pattern;
    int         kind;
    int         hold;
    kind = $urandom_range(0, 4);
    case (kind)
      0:       pattern = KeysOne;
      1:       pattern = KeysTwo;
      2:       pattern = tkdlp_pkg::KeysBoth;
      default: pattern = $urandom_range(0, 1) ? KeysOne : KeysTwo;
    endcase
    send_noise($urandom_range(0, 3));
    // both keys first, then one of them stays down
    if (kind == 4) send_pressed(tkdlp_pkg::KeysBoth, dbn + $urandom_range(1, 6));
    // long holds only where the long time is short enough to be cheap
    if (lng <= 64 && $urandom_range(0, 1)) hold = dbn + lng + $urandom_range(0, 6);
    else hold = $urandom_range(0, dbn + 8);
    send_pressed(pattern, hold);
    send_noise($urandom_range(0, 3));
    send_pressed(tkdlp_pkg::KeysNone, dbn + $urandom_range(1, 4));
  endtask

  // drop valid and wait for every predicted event to come out
  task automatic settle();
    key_bus.valid <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // both registers in back-to-back writes; debounce data carries junk above
  // its eight bits, which the block must drop
  task automatic configure(int dbn, int lng);
    logic [tkdlp_pkg::CfgDataW-1:0] dbn_word;
    dbn_word = {8'($urandom_range(0, 255)), 8'(dbn)};
    cfg_we <= 1'b1;
    cfg_index <= tkdlp_pkg::RegDebounce;
    cfg_data <= dbn_word;
    @(posedge clk);
    tracker.write_reg(tkdlp_pkg::RegDebounce, dbn_word);
    cfg_index <= tkdlp_pkg::RegLong;
    cfg_data <= tkdlp_pkg::CfgDataW'(lng);
    @(posedge clk);
    tracker.write_reg(tkdlp_pkg::RegLong, tkdlp_pkg::CfgDataW'(lng));
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int dbn, int lng, int count, int send_pct, int stall, bit squeeze);
    int stop_at;
    settle();
    configure(dbn, lng);
    send_idle_pct = send_pct;
    stall_pct <= stall;
    // receiver goes quiet for a while so the output register fills up
    if (squeeze) hold_requests <= hold_requests + 1;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) play_press(dbn, lng);
  endtask

  initial begin
    tracker = new();
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = tkdlp_pkg::RegDebounce;
    cfg_data = '0;
    key_bus.valid = 1'b0;
    key_bus.key_one_level = 1'b1;
    key_bus.key_two_level = 1'b1;
    event_bus.ready = 1'b0;
    send_idle_pct = 0;
    stall_pct = 0;
    ticks_sent = 0;
    hold_requests = 0;
    hold_served = 0;
    hold_left = 0;
    quiet_cycles = 0;

    repeat (ResetCycles) @(posedge clk);
    rst <= 1'b0;

    // hand-written presses with tiny debounce and long times
    settle();
    configure(1, 2);
    foreach (DirectedPresses[i]) send_pressed(DirectedPresses[i], 1);

    // reset timing, no idling
    run_phase(10, 1350, 250, 0, 0, 1'b0);
    // zero times: every wait ends on the next tick; sender idles
    run_phase(0, 0, 200, 58, 0, 1'b0);
    // receiver stalls, with one long hold-off
    run_phase(3, 20, 300, 0, 58, 1'b1);
    // widest register values, both sides idle; one press is several hundred ticks
    run_phase(255, 65535, 100, 32, 32, 1'b0);
    run_phase(2, 7, 200, 32, 32, 1'b1);
    run_phase(1, 40, 200, 0, 0, 1'b0);
    run_phase(0, 1, 150, 58, 0, 1'b0);

    settle();
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("two_key_debounce_long_press_tb: PASS");
    end else begin
      $display("two_key_debounce_long_press_tb: FAIL");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/tkdlp_pkg.sv
hdl/tkdlp_if.sv
hdl/tkdlp_fsm.sv
hdl/two_key_debounce_long_press.sv
hdl/tkdlp_checker.sv
tb/two_key_debounce_long_press_tb.sv
